/* rtl/lfu_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lfu_pkg
// Shared constants and controller/datapath interface types for the LFU
// page replacement block.
// ----------------------------------------------------------------------------
package lfu_pkg;

	localparam int FRAMES     = 8;
	localparam int FRAME_W    = 3;
	localparam int FCNT_W     = 4;
	localparam int CFG_W      = 4;
	localparam int PAGE_W     = 7;
	localparam int PAGE_SPACE = 128;
	localparam int COUNT_W    = 16;
	localparam int TIME_W     = 16;
	localparam int FAULT_W    = 16;

	localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(FRAMES);

	typedef struct packed {
		logic start;
		logic hscan_step;
		logic take_hit;
		logic miss_empty;
		logic miss_full;
		logic vscan;
		logic commit;
		logic inc;
		logic load_out;
	} lfu_cmd_t;

	typedef struct packed {
		logic page_bad;
		logic idx_end;
		logic match;
		logic empty_vld;
		logic vscan_done;
	} lfu_sts_t;

endpackage

`default_nettype wire

/* rtl/lfu_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lfu_ctrl
// Sequencer: hit scan, victim scan, frame commit, count update, result.
// ----------------------------------------------------------------------------
module lfu_ctrl (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  wire               out_ready,
	input  lfu_pkg::lfu_sts_t sts,
	output lfu_pkg::lfu_cmd_t cmd
);
	import lfu_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_HSCAN,
		S_VSCAN,
		S_COMMIT,
		S_INC,
		S_OUT
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.start = 1'b1;
					state_d   = S_HSCAN;
				end
			end
			S_HSCAN: begin
				priority if (sts.page_bad) begin
					state_d = S_OUT;
				end else if (sts.idx_end) begin
					if (sts.empty_vld) begin
						cmd.miss_empty = 1'b1;
						state_d        = S_COMMIT;
					end else begin
						cmd.miss_full = 1'b1;
						state_d       = S_VSCAN;
					end
				end else if (sts.match) begin
					cmd.take_hit = 1'b1;
					state_d      = S_INC;
				end else begin
					cmd.hscan_step = 1'b1;
				end
			end
			S_VSCAN: begin
				cmd.vscan = 1'b1;
				if (sts.vscan_done) begin
					state_d = S_COMMIT;
				end
			end
			S_COMMIT: begin
				cmd.commit = 1'b1;
				state_d    = S_INC;
			end
			S_INC: begin
				cmd.inc = 1'b1;
				state_d = S_OUT;
			end
			S_OUT: begin
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/lfu_dp.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lfu_dp
// Datapath: frame table, use count and load time memories, scan counter,
// victim compare, fault and request counters, result register.
// ----------------------------------------------------------------------------
module lfu_dp (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           cfg_wr_en,
	input  wire  [lfu_pkg::CFG_W-1:0]     cfg_wr_data,
	input  wire  [lfu_pkg::PAGE_W-1:0]    page_number,
	input  lfu_pkg::lfu_cmd_t             cmd,
	output lfu_pkg::lfu_sts_t             sts,
	output logic                          hit,
	output logic [lfu_pkg::FRAME_W-1:0]   frame_index,
	output logic [lfu_pkg::PAGE_W-1:0]    evicted_page,
	output logic [lfu_pkg::FAULT_W-1:0]   fault_count
);
	import lfu_pkg::*;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
	localparam logic [TIME_W-1:0]  TIME_MAX  = '1;
	localparam logic [FAULT_W-1:0] FAULT_MAX = '1;

	logic [CFG_W-1:0]   cfg_q;
	logic [FCNT_W-1:0]  n_act;
	logic [PAGE_W-1:0]  page_q;
	logic [PAGE_W-1:0]  frame_page_q [FRAMES];
	logic [FCNT_W-1:0]  idx_q;
	logic [FRAME_W-1:0] empty_idx_q;
	logic               empty_vld_q;
	logic [FRAME_W-1:0] victim_q;
	logic               hit_q;
	logic [PAGE_W-1:0]  evict_q;
	logic [TIME_W-1:0]  req_q;
	logic [FAULT_W-1:0] faults_q;

	logic [COUNT_W-1:0] ucnt_mem [PAGE_SPACE];
	logic [TIME_W-1:0]  lt_mem   [PAGE_SPACE];
	logic               ucnt_vld_q [PAGE_SPACE];
	logic [COUNT_W-1:0] rd_cnt_q;
	logic [TIME_W-1:0]  rd_lt_q;
	logic               rd_vld_q;

	logic               cmp_vld_s1;
	logic [FRAME_W-1:0] cmp_idx_s1;
	logic [COUNT_W-1:0] best_cnt_q;
	logic [TIME_W-1:0]  best_lt_q;

	logic [PAGE_W-1:0]  cur_page;
	logic [PAGE_W-1:0]  old_page;
	logic [PAGE_W-1:0]  raddr;
	logic [COUNT_W-1:0] cnt_i;
	logic [COUNT_W-1:0] new_cnt;
	logic               better;
	logic               issue;

	always_comb begin
		priority if (cfg_q == '0) begin
			n_act = FCNT_W'(1);
		end else if ({1'b0, cfg_q} > (CFG_W+1)'(FRAMES)) begin
			n_act = FCNT_W'(FRAMES);
		end else begin
			n_act = FCNT_W'(cfg_q);
		end
	end

	assign cur_page = frame_page_q[idx_q[FRAME_W-1:0]];
	assign old_page = frame_page_q[victim_q];
	assign raddr    = cmd.vscan ? cur_page : page_q;
	assign issue    = cmd.vscan && (idx_q != n_act);

	assign cnt_i   = rd_vld_q ? rd_cnt_q : '0;
	assign better  = (cmp_idx_s1 == '0) || (cnt_i < best_cnt_q) ||
		((cnt_i == best_cnt_q) && (rd_lt_q < best_lt_q));
	assign new_cnt = (cnt_i == COUNT_MAX) ? cnt_i : cnt_i + COUNT_W'(1);

	assign sts.page_bad   = (page_q == '0) ||
		({1'b0, page_q} >= (PAGE_W+1)'(PAGE_SPACE));
	assign sts.idx_end    = (idx_q == n_act);
	assign sts.match      = (cur_page == page_q);
	assign sts.empty_vld  = empty_vld_q;
	assign sts.vscan_done = (idx_q == n_act) && !cmp_vld_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q       <= CFG_RESET;
			idx_q       <= '0;
			empty_vld_q <= 1'b0;
			req_q       <= '0;
			faults_q    <= '0;
			cmp_vld_s1  <= 1'b0;
			for (int i = 0; i < FRAMES; i++) begin
				frame_page_q[i] <= '0;
			end
			for (int i = 0; i < PAGE_SPACE; i++) begin
				ucnt_vld_q[i] <= 1'b0;
			end
		end else begin
			if (cfg_wr_en) begin
				cfg_q <= cfg_wr_data;
			end
			cmp_vld_s1 <= issue;
			if (cmd.start || cmd.miss_full) begin
				idx_q <= '0;
			end else if (cmd.hscan_step || issue) begin
				idx_q <= idx_q + FCNT_W'(1);
			end
			if (cmd.start) begin
				empty_vld_q <= 1'b0;
			end else if (cmd.hscan_step && (cur_page == '0) && !empty_vld_q) begin
				empty_vld_q <= 1'b1;
			end
			if ((cmd.miss_empty || cmd.miss_full) && (faults_q != FAULT_MAX)) begin
				faults_q <= faults_q + FAULT_W'(1);
			end
			if (cmd.commit) begin
				frame_page_q[victim_q] <= page_q;
				if (old_page != '0) begin
					ucnt_vld_q[old_page] <= 1'b0;
				end
			end
			if (cmd.inc) begin
				ucnt_vld_q[page_q] <= 1'b1;
				if (req_q != TIME_MAX) begin
					req_q <= req_q + TIME_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_cnt_q   <= ucnt_mem[raddr];
		rd_lt_q    <= lt_mem[raddr];
		rd_vld_q   <= ucnt_vld_q[raddr];
		cmp_idx_s1 <= idx_q[FRAME_W-1:0];
		if (cmd.inc) begin
			ucnt_mem[page_q] <= new_cnt;
		end
		if (cmd.commit) begin
			lt_mem[page_q] <= req_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			page_q   <= page_number;
			hit_q    <= 1'b0;
			evict_q  <= '0;
			victim_q <= '0;
		end
		if (cmd.hscan_step && (cur_page == '0) && !empty_vld_q) begin
			empty_idx_q <= idx_q[FRAME_W-1:0];
		end
		if (cmd.take_hit) begin
			hit_q    <= 1'b1;
			victim_q <= idx_q[FRAME_W-1:0];
		end
		if (cmd.miss_empty) begin
			victim_q <= empty_idx_q;
		end
		if (cmp_vld_s1 && better) begin
			victim_q   <= cmp_idx_s1;
			best_cnt_q <= cnt_i;
			best_lt_q  <= rd_lt_q;
		end
		if (cmd.commit) begin
			evict_q <= old_page;
		end
		if (cmd.load_out) begin
			hit          <= hit_q;
			frame_index  <= victim_q;
			evicted_page <= evict_q;
			fault_count  <= faults_q;
		end
	end

endmodule

`default_nettype wire

/* rtl/lfu_page_replacement.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lfu_page_replacement
// LFU page replacement with first-in tie-break over up to eight frames.
// ----------------------------------------------------------------------------
// One page reference per item, one result item per reference. With n active
// frames a reserved page number goes straight to the result, a hit in frame k
// walks frames 0 to k and updates the use count, a fault into an empty frame
// walks all n frames, commits and updates, and an evicting fault adds a victim
// scan of the n frames. The walk takes one frame a cycle in the hit scan and
// one use-count and load-time memory read a cycle in the victim scan. A new
// item is taken once the previous result sits in the output register.
module lfu_page_replacement (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           cfg_wr_en,
	input  wire  [lfu_pkg::CFG_W-1:0]     cfg_wr_data,
	input  wire                           in_valid,
	output logic                          in_ready,
	input  wire  [lfu_pkg::PAGE_W-1:0]    page_number,
	output logic                          out_valid,
	input  wire                           out_ready,
	output logic                          hit,
	output logic [lfu_pkg::FRAME_W-1:0]   frame_index,
	output logic [lfu_pkg::PAGE_W-1:0]    evicted_page,
	output logic [lfu_pkg::FAULT_W-1:0]   fault_count
);
	import lfu_pkg::*;

	lfu_cmd_t cmd;
	lfu_sts_t sts;

	lfu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	lfu_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.page_number  (page_number),
		.cmd          (cmd),
		.sts          (sts),
		.hit          (hit),
		.frame_index  (frame_index),
		.evicted_page (evicted_page),
		.fault_count  (fault_count)
	);

endmodule

`default_nettype wire

/* tb/sv/lfu_page_replacement_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfu_page_replacement_tb
// Self-checking bench for the LFU page replacement block. A queue-fed driver
// sends page references and a monitor checks every result item against an
// in-bench LFU model with first-in tie-break. The frame count is swept
// through legal and out-of-range values, and sender/receiver idling varies
// from phase to phase.
// ----------------------------------------------------------------------------
module lfu_page_replacement_tb;
	import lfu_pkg::*;

	typedef struct packed {
		logic               hit;
		logic [FRAME_W-1:0] frame;
		logic [PAGE_W-1:0]  evicted;
		logic [FAULT_W-1:0] faults;
	} page_outcome_t;

	logic               clk         = 1'b0;
	logic               arst_n      = 1'b0;
	logic               cfg_wr_en   = 1'b0;
	logic [CFG_W-1:0]   cfg_wr_data = CFG_RESET;
	logic               in_valid    = 1'b0;
	logic               in_ready;
	logic [PAGE_W-1:0]  page_number = '0;
	logic               out_valid;
	logic               out_ready   = 1'b0;
	logic               hit;
	logic [FRAME_W-1:0] frame_index;
	logic [PAGE_W-1:0]  evicted_page;
	logic [FAULT_W-1:0] fault_count;

	// model state
	logic [CFG_W-1:0]   frames_cfg;
	logic [PAGE_W-1:0]  frame_pg [FRAMES];
	logic [COUNT_W-1:0] use_cnt [PAGE_SPACE];
	logic [TIME_W-1:0]  loaded_at [PAGE_SPACE];
	logic [TIME_W-1:0]  req_seq;
	logic [FAULT_W-1:0] fault_total;

	logic [PAGE_W-1:0] page_q [$];
	page_outcome_t     outcome_q [$];
	int                send_idle_pct = 0;
	int                recv_stall_pct = 0;
	int                err_count = 0;

	lfu_page_replacement i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.page_number  (page_number),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.hit          (hit),
		.frame_index  (frame_index),
		.evicted_page (evicted_page),
		.fault_count  (fault_count)
	);

	always #5 clk = ~clk;

	function automatic page_outcome_t lfu_lookup(input logic [PAGE_W-1:0] pg);
		page_outcome_t r;
		int n;
		int v;
		int i;
		logic found;
		r = '0;
		r.faults = fault_total;
		if (pg == '0)
			return r;
		n = (frames_cfg == '0) ? 1 : ((frames_cfg > FRAMES) ? FRAMES : int'(frames_cfg));
		found = 1'b0;
		for (i = 0; i < n; i++) begin
			if (!found && frame_pg[i] == pg) begin
				found = 1'b1;
				r.hit = 1'b1;
				r.frame = FRAME_W'(i);
			end
		end
		if (!found) begin
			if (fault_total != '1)
				fault_total++;
			v = -1;
			for (i = 0; i < n; i++)
				if (v < 0 && frame_pg[i] == '0)
					v = i;
			if (v < 0) begin
				v = 0;
				for (i = 1; i < n; i++) begin
					if (use_cnt[frame_pg[i]] < use_cnt[frame_pg[v]] ||
					    (use_cnt[frame_pg[i]] == use_cnt[frame_pg[v]] &&
					     loaded_at[frame_pg[i]] < loaded_at[frame_pg[v]]))
						v = i;
				end
			end
			r.frame = FRAME_W'(v);
			r.evicted = frame_pg[v];
			if (frame_pg[v] != '0)
				use_cnt[frame_pg[v]] = '0;
			frame_pg[v] = pg;
			loaded_at[pg] = req_seq;
			r.faults = fault_total;
		end
		if (use_cnt[pg] != '1)
			use_cnt[pg]++;
		if (req_seq != '1)
			req_seq++;
		return r;
	endfunction

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			err_count++;
		end
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			page_number <= '0;
		end else if (!in_valid || in_ready) begin
			if (page_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				in_valid <= 1'b1;
				page_number <= page_q.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_ready <= 1'b0;
		else
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// monitor
	always @(posedge clk) begin
		page_outcome_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (outcome_q.size() == 0) begin
					$display("%0t: unexpected result, hit %0d frame %0d evicted %0d faults %0d",
						$time, hit, frame_index, evicted_page, fault_count);
					err_count++;
				end else begin
					want = outcome_q.pop_front();
					check_field("hit", int'(want.hit), int'(hit));
					check_field("frame_index", int'(want.frame), int'(frame_index));
					check_field("evicted_page", int'(want.evicted), int'(evicted_page));
					check_field("fault_count", int'(want.faults), int'(fault_count));
				end
			end
			if (in_valid && in_ready)
				outcome_q = {outcome_q, lfu_lookup(page_number)};
			if (cfg_wr_en)
				frames_cfg = cfg_wr_data;
		end
	end

	task automatic wait_idle();
		do
			@(negedge clk);
		while (page_q.size() != 0 || in_valid || outcome_q.size() != 0);
	endtask

	task automatic set_frames(input logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	initial begin
		logic [CFG_W-1:0] sweep [9];
		logic [PAGE_W-1:0] directed [20];
		int n;
		int base;
		int roll;
		frames_cfg = CFG_RESET;
		for (int i = 0; i < FRAMES; i++)
			frame_pg[i] = '0;
		for (int i = 0; i < PAGE_SPACE; i++) begin
			use_cnt[i] = '0;
			loaded_at[i] = '0;
		end
		req_seq = '0;
		fault_total = '0;
		sweep = '{4'd2, 4'd0, 4'd15, 4'd1, 4'd8, 4'd5, 4'd9, 4'd3, 4'd8};
		directed = '{7'd0, 7'd1, 7'd2, 7'd3, 7'd4, 7'd5, 7'd6, 7'd7, 7'd127, 7'd1,
			7'd1, 7'd2, 7'd127, 7'd64, 7'd65, 7'd3, 7'd0, 7'd85, 7'd42, 7'd127};

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// fill, hits, LFU evictions with load-time ties, reserved page
		@(negedge clk);
		foreach (directed[i])
			page_q = {page_q, directed[i]};
		wait_idle();

		foreach (sweep[ph]) begin
			set_frames(sweep[ph]);
			@(negedge clk);
			case (ph % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
				default: begin send_idle_pct = 16; recv_stall_pct = 16; end
			endcase
			n = (sweep[ph] == 0) ? 1 : ((sweep[ph] > FRAMES) ? FRAMES : int'(sweep[ph]));
			base = 1 + 6 * $urandom_range(3);
			for (int k = 0; k < 67; k++) begin
				roll = $urandom_range(99);
				if (roll < 65)
					page_q = {page_q, PAGE_W'(base + $urandom_range(n + 2))};
				else if (roll < 95)
					page_q = {page_q, PAGE_W'($urandom_range(127, 1))};
				else
					page_q = {page_q, PAGE_W'(0)};
			end
			wait_idle();
		end

		repeat (30) @(posedge clk);
		if (err_count == 0)
			$display("lfu_page_replacement_tb: done, clean");
		else
			$display("lfu_page_replacement_tb: done, errors");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("lfu_page_replacement_tb: done, errors");
		$finish;
	end

endmodule
